// ----- hdl/dtcd_pkg.sv -----
// ----------------------------------------------------------------------------
// dtcd_pkg
// Shared widths, constants and the month start table for the day count to
// calendar date converter.
// ----------------------------------------------------------------------------
package dtcd_pkg;

    // field widths
    localparam int DAY_W   = 20;
    localparam int YEAR_W  = 13;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;

    // internal widths: day of year, four-year block index, block remainder
    localparam int DOY_W = 9;
    localparam int QUO_W = 10;
    localparam int REM_W = 12;

    // calendar constants
    localparam logic [DAY_W-1:0]  FIRST_BLOCK = 20'd1460;
    localparam logic [10:0]       LEAP_BLOCK  = 11'd1461;
    localparam logic [YEAR_W-1:0] BASE_YEAR   = 13'd1900;
    localparam logic [YEAR_W-1:0] LEAP_BASE   = 13'd1904;

    // reciprocal of the four-year block length, scaled by 2^RECIP_SHIFT
    localparam int                RECIP_SHIFT = 30;
    localparam logic [DAY_W-1:0]  RECIP       = 20'd734936;

    // day of year and leap flag handed to the month stages
    typedef struct packed {
        logic [DOY_W-1:0] doy;
        logic             leap;
    } t_doy;

    // zero-based day of year on which a month starts
    function automatic logic [DOY_W-1:0] month_start(
        input logic [MONTH_W-1:0] idx,
        input logic               leap
    );
        logic [DOY_W-1:0] base;
        logic [DOY_W-1:0] adj;
        begin
            case (idx)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            // leap day pushes every month after february by one
            adj = (leap && (idx >= 4'd2)) ? 9'd1 : 9'd0;
            month_start = base + adj;
        end
    endfunction

endpackage

// ----- hdl/dtcd_month.sv -----
// ----------------------------------------------------------------------------
// dtcd_month
// Two pipeline stages that turn a day of year into month and day of month:
// parallel compares against the month start table, then the subtract.
// ----------------------------------------------------------------------------
module dtcd_month (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  dtcd_pkg::t_doy                  i_doy,
    output logic [dtcd_pkg::MONTH_W-1:0]    o_month,
    output logic [dtcd_pkg::DOM_W-1:0]      o_day_of_month
);

    logic [dtcd_pkg::MONTH_W-1:0] n_idx;
    logic [dtcd_pkg::MONTH_W-1:0] r_idx;
    dtcd_pkg::t_doy               r_doy;
    logic [dtcd_pkg::DOY_W-1:0]   n_dom;
    logic [dtcd_pkg::MONTH_W-1:0] r_month;
    logic [dtcd_pkg::DOM_W-1:0]   r_dom;

    // last month whose start is not past the day of year
    always_comb begin
        n_idx = '0;
        for (int i = 1; i < 12; i++) begin
            if (i_doy.doy >= dtcd_pkg::month_start(4'(i), i_doy.leap)) begin
                n_idx = 4'(i);
            end
        end
    end

    // offset within the month, one based
    assign n_dom = r_doy.doy - dtcd_pkg::month_start(r_idx, r_doy.leap) + 9'd1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx   <= n_idx;
            r_doy   <= i_doy;
            r_month <= r_idx + 4'd1;
            r_dom   <= n_dom[dtcd_pkg::DOM_W-1:0];
        end
    end

    assign o_month        = r_month;
    assign o_day_of_month = r_dom;

endmodule

// ----- hdl/days_to_calendar_date_top.sv -----
// Throughput: one word per cycle; the pipeline advances whenever the output
// register is empty or taken, so a downstream stall holds every stage.
// Reset clears the stage valid bits only; payload registers are not reset.
// Stages: offset, reciprocal multiply, remainder, correction, year split,
// month select, day subtract.
// ----------------------------------------------------------------------------
// days_to_calendar_date_top
// Converts a day count since 1 January 1900 into year, month and day of
// month, with the four-year leap rule that skips only 1900.
// ----------------------------------------------------------------------------
module days_to_calendar_date_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [dtcd_pkg::DAY_W-1:0]      i_day_count,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [dtcd_pkg::YEAR_W-1:0]     o_year,
    output logic [dtcd_pkg::MONTH_W-1:0]    o_month,
    output logic [dtcd_pkg::DOM_W-1:0]      o_day_of_month
);

    logic       en;
    logic [7:1] r_v;

    logic                          r1_first;
    logic [dtcd_pkg::DAY_W-1:0]    r1_d;
    logic [39:0]                   prod2;
    logic                          r2_first;
    logic [dtcd_pkg::DAY_W-1:0]    r2_d;
    logic [dtcd_pkg::QUO_W-1:0]    r2_q;
    logic [20:0]                   prod3;
    logic [dtcd_pkg::DAY_W-1:0]    diff3;
    logic                          r3_first;
    logic [dtcd_pkg::REM_W-1:0]    r3_d;
    logic [dtcd_pkg::QUO_W-1:0]    r3_q;
    logic [dtcd_pkg::REM_W-1:0]    r3_rem;
    logic                          r4_first;
    logic [dtcd_pkg::REM_W-1:0]    r4_d;
    logic [dtcd_pkg::QUO_W-1:0]    r4_q;
    logic [dtcd_pkg::REM_W-1:0]    r4_rem;
    logic [1:0]                    n_yoff;
    logic [dtcd_pkg::REM_W-1:0]    n_doy;
    logic [dtcd_pkg::REM_W-1:0]    yr_src;
    logic [dtcd_pkg::YEAR_W-1:0]   n_year;
    dtcd_pkg::t_doy                r5_doy;
    logic [dtcd_pkg::YEAR_W-1:0]   r5_year;
    logic [dtcd_pkg::YEAR_W-1:0]   r6_year;
    logic [dtcd_pkg::YEAR_W-1:0]   r7_year;

    // whole pipeline moves unless the output word is held
    assign en      = !(r_v[7] && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[6:1], i_valid};
        end
    end

    // stage 1: split off the first four common years
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_first <= (i_day_count < dtcd_pkg::FIRST_BLOCK);
            r1_d     <= (i_day_count < dtcd_pkg::FIRST_BLOCK) ? i_day_count
                        : i_day_count - dtcd_pkg::FIRST_BLOCK;
        end
    end

    // stage 2: block index estimate by reciprocal multiply, low by at most one
    assign prod2 = 40'(r1_d) * 40'(dtcd_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_first <= r1_first;
            r2_d     <= r1_d;
            r2_q     <= prod2[dtcd_pkg::RECIP_SHIFT +: dtcd_pkg::QUO_W];
        end
    end

    // stage 3: remainder of the estimate
    assign prod3 = 21'(r2_q) * 21'(dtcd_pkg::LEAP_BLOCK);
    assign diff3 = r2_d - prod3[dtcd_pkg::DAY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_first <= r2_first;
            r3_d     <= r2_d[dtcd_pkg::REM_W-1:0];
            r3_q     <= r2_q;
            r3_rem   <= diff3[dtcd_pkg::REM_W-1:0];
        end
    end

    // stage 4: fix up an estimate that came out one short
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_first <= r3_first;
            r4_d     <= r3_d;
            if (r3_rem >= 12'(dtcd_pkg::LEAP_BLOCK)) begin
                r4_q   <= r3_q + 10'd1;
                r4_rem <= r3_rem - 12'(dtcd_pkg::LEAP_BLOCK);
            end else begin
                r4_q   <= r3_q;
                r4_rem <= r3_rem;
            end
        end
    end

    // stage 5: year within the block and day of year
    always_comb begin
        if (r4_first) begin
            yr_src = r4_d;
            if (r4_d >= 12'd1095) begin
                n_yoff = 2'd3;
                n_doy  = r4_d - 12'd1095;
            end else if (r4_d >= 12'd730) begin
                n_yoff = 2'd2;
                n_doy  = r4_d - 12'd730;
            end else if (r4_d >= 12'd365) begin
                n_yoff = 2'd1;
                n_doy  = r4_d - 12'd365;
            end else begin
                n_yoff = 2'd0;
                n_doy  = r4_d;
            end
            n_year = dtcd_pkg::BASE_YEAR + 13'(n_yoff);
        end else begin
            yr_src = r4_rem;
            if (r4_rem >= 12'd1096) begin
                n_yoff = 2'd3;
                n_doy  = r4_rem - 12'd1096;
            end else if (r4_rem >= 12'd731) begin
                n_yoff = 2'd2;
                n_doy  = r4_rem - 12'd731;
            end else if (r4_rem >= 12'd366) begin
                n_yoff = 2'd1;
                n_doy  = r4_rem - 12'd366;
            end else begin
                n_yoff = 2'd0;
                n_doy  = r4_rem;
            end
            n_year = dtcd_pkg::LEAP_BASE + {1'b0, r4_q, 2'b00} + 13'(n_yoff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_doy.doy  <= n_doy[dtcd_pkg::DOY_W-1:0];
            // first year of each later block is the leap year; 1900 never is
            r5_doy.leap <= !r4_first && (n_yoff == 2'd0) && (yr_src != '1);
            r5_year     <= n_year;
        end
    end

    // stages 6 and 7: month walk
    dtcd_month u_month (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_doy          (r5_doy),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_year <= r5_year;
            r7_year <= r6_year;
        end
    end

    assign o_valid = r_v[7];
    assign o_year  = r7_year;

endmodule
